/* rtl/sst_pkg.sv */
// Shared constants, types and register codes of the speech segment tracker.
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

   // Samples in one full frame.
   localparam int unsigned FRAME_LEN = 512;

   // Field widths.
   localparam int unsigned PROB_W   = 16;
   localparam int unsigned VALID_W  = 10;
   localparam int unsigned THRESH_W = 17;
   localparam int unsigned CFG_W    = 20;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned INDEX_W  = 2;

   // Result queue geometry.
   localparam int unsigned RSP_DEPTH = 4;
   localparam int unsigned RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int unsigned RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // Configuration register indexes.
   localparam logic [INDEX_W-1:0] REG_SPEECH_THRESHOLD  = 2'd0;
   localparam logic [INDEX_W-1:0] REG_MIN_GAP_SAMPLES   = 2'd1;
   localparam logic [INDEX_W-1:0] REG_GRACE_SAMPLES     = 2'd2;
   localparam logic [INDEX_W-1:0] REG_MIN_CHUNK_SAMPLES = 2'd3;

   // Item kinds carried on the request tuser.
   localparam logic MODE_FRAME = 1'b0;
   localparam logic MODE_END   = 1'b1;

   typedef struct packed {
      logic [THRESH_W-1:0] speech_threshold;
      logic [CFG_W-1:0]    min_gap_samples;
      logic [CFG_W-1:0]    grace_samples;
      logic [CFG_W-1:0]    min_chunk_samples;
   } cfg_type;

   typedef struct packed {
      logic              talking;
      logic              gap_pending;
      logic [TIME_W-1:0] open_start;
      logic [TIME_W-1:0] gap_start;
      logic [TIME_W-1:0] frame_position;
      logic [TIME_W-1:0] sample_total;
      logic              held_valid;
      logic [TIME_W-1:0] held_start;
      logic [TIME_W-1:0] held_end;
   } seg_state_type;

   typedef struct packed {
      logic [TIME_W-1:0] seg_start;
      logic [TIME_W-1:0] seg_end;
      logic              has_segment;
      logic              stream_done;
   } rsp_item_type;

   // Up to two result items from one input item.
   typedef struct packed {
      logic [1:0]         count;
      rsp_item_type [1:0] items;
   } seg_result_type;

endpackage

`default_nettype wire

/* rtl/sst_seg_logic.sv */
// Per-item segmentation logic: next tracker state and the result items of one input item.
`timescale 1ns / 1ps
`default_nettype none

module sst_seg_logic (
   input  wire  sst_pkg::cfg_type                 cfg,
   input  wire  sst_pkg::seg_state_type           st,
   input  wire                                    mode,
   input  wire  [sst_pkg::PROB_W-1:0]             speech_prob,
   input  wire  [sst_pkg::VALID_W-1:0]            valid_samples,
   output sst_pkg::seg_state_type                 st_next,
   output sst_pkg::seg_result_type                result
);

   // Emission check of the held segment: clamp its end to the samples seen.
   function automatic sst_pkg::rsp_item_type held_emit(
      input logic                       hv,
      input logic [sst_pkg::TIME_W-1:0] hs,
      input logic [sst_pkg::TIME_W-1:0] he,
      input logic [sst_pkg::TIME_W-1:0] total,
      input logic [sst_pkg::CFG_W-1:0]  min_chunk
   );
      sst_pkg::rsp_item_type r;
      logic [sst_pkg::TIME_W-1:0] ce;
      ce = (he < total) ? he : total;
      r.seg_start   = hs;
      r.seg_end     = ce;
      r.has_segment = hv && (ce >= hs) &&
                      ((ce - hs) >= {{(sst_pkg::TIME_W - sst_pkg::CFG_W){1'b0}}, min_chunk});
      r.stream_done = 1'b0;
      return r;
   endfunction

   logic [sst_pkg::TIME_W-1:0]    vs;
   logic [sst_pkg::TIME_W-1:0]    total_frame;
   logic [sst_pkg::TIME_W-1:0]    total_use;
   logic [sst_pkg::TIME_W-1:0]    next_pos;
   logic [sst_pkg::TIME_W-1:0]    gap_dur;
   logic [sst_pkg::TIME_W-1:0]    grace32;
   logic                          speech;
   logic                          gap_hit;
   logic                          do_close;
   logic [sst_pkg::TIME_W-1:0]    close_e0;
   logic [sst_pkg::TIME_W-1:0]    pad_s;
   logic [sst_pkg::TIME_W:0]      pad_ew;
   logic [sst_pkg::TIME_W-1:0]    pad_e;
   logic [sst_pkg::TIME_W-1:0]    pad_ce;
   logic                          hv;
   logic [sst_pkg::TIME_W-1:0]    hs;
   logic [sst_pkg::TIME_W-1:0]    he;
   sst_pkg::rsp_item_type         r_close;
   sst_pkg::rsp_item_type         r_flush;

   // Frame bookkeeping: saturated sample count, speech decision and gap length.
   always_comb begin
      if (sst_pkg::TIME_W'(valid_samples) > sst_pkg::TIME_W'(sst_pkg::FRAME_LEN)) begin
         vs = sst_pkg::TIME_W'(sst_pkg::FRAME_LEN);
      end else begin
         vs = sst_pkg::TIME_W'(valid_samples);
      end
      total_frame = st.sample_total + vs;
      total_use   = (mode == sst_pkg::MODE_END) ? st.sample_total : total_frame;
      next_pos    = st.frame_position + sst_pkg::TIME_W'(sst_pkg::FRAME_LEN);
      gap_dur     = next_pos - st.gap_start;
      speech      = {1'b0, speech_prob} >= cfg.speech_threshold;
      gap_hit     = st.talking && !speech && st.gap_pending &&
                    (gap_dur >= {{(sst_pkg::TIME_W - sst_pkg::CFG_W){1'b0}},
                                 cfg.min_gap_samples});
      grace32     = {{(sst_pkg::TIME_W - sst_pkg::CFG_W){1'b0}}, cfg.grace_samples};
   end

   // Segment close: pad, drop empty ones, merge or hand over the held segment.
   always_comb begin
      if (mode == sst_pkg::MODE_END) begin
         do_close = st.talking;
         close_e0 = st.gap_pending ? st.gap_start : st.sample_total;
      end else begin
         do_close = gap_hit;
         close_e0 = st.gap_start;
      end
      pad_s  = (st.open_start >= grace32) ? (st.open_start - grace32) : '0;
      pad_ew = {1'b0, close_e0} + {1'b0, grace32};
      pad_e  = pad_ew[sst_pkg::TIME_W] ? '1 : pad_ew[sst_pkg::TIME_W-1:0];
      pad_ce = (pad_e < total_use) ? pad_e : total_use;

      hv = st.held_valid;
      hs = st.held_start;
      he = st.held_end;
      r_close = '0;
      if (do_close && (pad_ce > pad_s)) begin
         if (hv && (pad_s <= he)) begin
            if (pad_e > he) begin
               he = pad_e;
            end
         end else begin
            r_close = held_emit(hv, hs, he, total_use, cfg.min_chunk_samples);
            hv = 1'b1;
            hs = pad_s;
            he = pad_e;
         end
      end
      r_flush = held_emit(hv, hs, he, total_use, cfg.min_chunk_samples);
   end

   // Next state and result list.
   always_comb begin
      st_next = st;
      result  = '0;
      if (mode == sst_pkg::MODE_END) begin
         st_next = '0;
         priority if (r_close.has_segment && r_flush.has_segment) begin
            result.count    = 2'd2;
            result.items[0] = r_close;
            result.items[1] = r_flush;
            result.items[1].stream_done = 1'b1;
         end else if (r_close.has_segment) begin
            result.count    = 2'd1;
            result.items[0] = r_close;
            result.items[0].stream_done = 1'b1;
         end else if (r_flush.has_segment) begin
            result.count    = 2'd1;
            result.items[0] = r_flush;
            result.items[0].stream_done = 1'b1;
         end else begin
            // Bare end marker.
            result.count = 2'd1;
            result.items[0].stream_done = 1'b1;
         end
      end else begin
         st_next.sample_total   = total_frame;
         st_next.frame_position = next_pos;
         st_next.held_valid     = hv;
         st_next.held_start     = hs;
         st_next.held_end       = he;
         priority if (!st.talking) begin
            if (speech) begin
               st_next.talking      = 1'b1;
               st_next.open_start   = st.frame_position;
               st_next.gap_pending  = 1'b0;
            end
         end else if (speech) begin
            st_next.gap_pending = 1'b0;
         end else if (!st.gap_pending) begin
            st_next.gap_pending = 1'b1;
            st_next.gap_start   = st.frame_position;
         end else begin
            // Silence goes on: the segment ends once the gap is long enough.
            if (gap_hit) begin
               st_next.talking     = 1'b0;
               st_next.gap_pending = 1'b0;
            end
         end
         if (r_close.has_segment) begin
            result.count    = 2'd1;
            result.items[0] = r_close;
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/sst_rsp_fifo.sv */
// Result queue: takes up to two items a cycle and hands out one.
`timescale 1ns / 1ps
`default_nettype none

module sst_rsp_fifo (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  sst_pkg::seg_result_type       push,
   input  wire                                 pop,
   output sst_pkg::rsp_item_type               head,
   output logic [sst_pkg::RSP_CNT_W-1:0]       count
);

   sst_pkg::rsp_item_type                 mem [sst_pkg::RSP_DEPTH];
   logic [sst_pkg::RSP_PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [sst_pkg::RSP_PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [sst_pkg::RSP_CNT_W-1:0]         count_ff, count_in;
   logic [sst_pkg::RSP_PTR_W-1:0]         wr_ptr_next;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_next = wr_ptr_ff + sst_pkg::RSP_PTR_W'(1);
      wr_ptr_in   = wr_ptr_ff + sst_pkg::RSP_PTR_W'(push.count);
      rd_ptr_in   = rd_ptr_ff + sst_pkg::RSP_PTR_W'(pop);
      count_in    = count_ff + sst_pkg::RSP_CNT_W'(push.count) - sst_pkg::RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage writes: the first item at the write pointer, a second one after it.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.items[0];
      end
      if (push.count == 2'd2) begin
         mem[wr_ptr_next] <= push.items[1];
      end
   end

   assign head  = mem[rd_ptr_ff];
   assign count = count_ff;

endmodule

`default_nettype wire

/* rtl/speech_segment_tracker.sv */
// Top level of the speech segment tracker: ports, registers, input stage and result queue.
`timescale 1ns / 1ps
`default_nettype none

// The tracker takes one frame item per clock cycle while the result queue
// has room for two results. An item is captured in an input register and
// then processed in a single pass by the segmentation logic, which writes
// its results into a four-item result queue; they are offered on the rsp
// channel in queue order. A frame item gives at most one result, an end item
// one or two, and an item is processed only while at least two queue slots
// are free, so the input rate is set by how fast the consumer drains the
// queue. Configuration writes are taken at any time and must only be made
// while the block is idle.
module speech_segment_tracker (
   input  wire                              clock,
   input  wire                              reset,
   // Frame items.
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [31:0]                      req_tdata,  // speech_prob[15:0], valid_samples[25:16]
   input  wire                              req_tuser,  // mode
   // Result items.
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [63:0]                      rsp_tdata,  // seg_start[31:0], seg_end[63:32]
   output logic                             rsp_tuser,  // has_segment
   output logic                             rsp_tlast,  // stream_done
   // Configuration writes.
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [sst_pkg::INDEX_W-1:0]      csr_index,
   input  wire  [sst_pkg::CFG_W-1:0]        csr_data
);

   sst_pkg::cfg_type                        cfg_ff, cfg_in;
   sst_pkg::seg_state_type                  st_ff, st_in;
   sst_pkg::seg_state_type                  st_calc;
   sst_pkg::seg_result_type                 result;
   sst_pkg::seg_result_type                 push;
   sst_pkg::rsp_item_type                   head;
   logic [sst_pkg::RSP_CNT_W-1:0]           rsp_count;

   logic                                    in_valid_ff, in_valid_in;
   logic                                    in_mode_ff;
   logic [sst_pkg::PROB_W-1:0]              in_prob_ff;
   logic [sst_pkg::VALID_W-1:0]             in_vs_ff;
   logic                                    proc;
   logic                                    req_take;
   logic                                    pop;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            sst_pkg::REG_SPEECH_THRESHOLD:
               cfg_in.speech_threshold = csr_data[sst_pkg::THRESH_W-1:0];
            sst_pkg::REG_MIN_GAP_SAMPLES:   cfg_in.min_gap_samples   = csr_data;
            sst_pkg::REG_GRACE_SAMPLES:     cfg_in.grace_samples     = csr_data;
            sst_pkg::REG_MIN_CHUNK_SAMPLES: cfg_in.min_chunk_samples = csr_data;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speech_threshold  <= sst_pkg::THRESH_W'(32768);
         cfg_ff.min_gap_samples   <= sst_pkg::CFG_W'(4800);
         cfg_ff.grace_samples     <= sst_pkg::CFG_W'(800);
         cfg_ff.min_chunk_samples <= sst_pkg::CFG_W'(3200);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input stage: the held item is processed once the queue has room for two results.
   assign proc       = in_valid_ff && (rsp_count <= sst_pkg::RSP_CNT_W'(sst_pkg::RSP_DEPTH - 2));
   assign req_tready = !in_valid_ff || proc;
   assign req_take   = req_tvalid && req_tready;
   assign in_valid_in = req_take || (in_valid_ff && !proc);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff <= req_tuser;
         in_prob_ff <= req_tdata[15:0];
         in_vs_ff   <= req_tdata[25:16];
      end
   end

   // Segmentation pass.
   sst_seg_logic u_seg_logic (
      .cfg           (cfg_ff),
      .st            (st_ff),
      .mode          (in_mode_ff),
      .speech_prob   (in_prob_ff),
      .valid_samples (in_vs_ff),
      .st_next       (st_calc),
      .result        (result)
   );

   // Tracker state.
   assign st_in = proc ? st_calc : st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else begin
         st_ff <= st_in;
      end
   end

   // Result queue and output.
   always_comb begin
      push = result;
      if (!proc) begin
         push.count = 2'd0;
      end
   end

   assign pop = rsp_tvalid && rsp_tready;

   sst_rsp_fifo u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .count (rsp_count)
   );

   assign rsp_tvalid = (rsp_count != '0);
   assign rsp_tdata  = {head.seg_end, head.seg_start};
   assign rsp_tuser  = head.has_segment;
   assign rsp_tlast  = head.stream_done;

   // The queue never overfills.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_count <= sst_pkg::RSP_CNT_W'(sst_pkg::RSP_DEPTH))
      else $error("result queue overfilled");

   // A pending gap only exists inside a speech segment.
   a_gap_in_speech: assert property (@(posedge clock) disable iff (reset)
      st_ff.gap_pending |-> st_ff.talking)
      else $error("gap pending outside a segment");

   // An end item leaves the tracker cleared for a new stream.
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (proc && (in_mode_ff == sst_pkg::MODE_END)) |=>
         (!st_ff.talking && !st_ff.held_valid && (st_ff.sample_total == '0)))
      else $error("state not cleared after end item");

   // An end item always queues a result flagged as the stream's last.
   a_end_marks_done: assert property (@(posedge clock) disable iff (reset)
      (proc && (in_mode_ff == sst_pkg::MODE_END)) |->
         (push.count != 2'd0) &&
         (push.items[push.count == 2'd2 ? 1 : 0].stream_done))
      else $error("end item without a done marker");

endmodule

`default_nettype wire

/* verif/speech_segment_tracker_test.sv */
// Self-checking testbench of the speech segment tracker: predicts segments per item and checks.
`timescale 1ns / 1ps

module speech_segment_tracker_test;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned SETTLE_CYCLES = 4;

   // Keeps its own copy of the registers and the tracker state, and a queue of
   // the segment items that the block still owes.
   class segment_ledger;
      logic [sst_pkg::THRESH_W-1:0] thr;
      logic [sst_pkg::CFG_W-1:0]    min_gap;
      logic [sst_pkg::CFG_W-1:0]    grace;
      logic [sst_pkg::CFG_W-1:0]    min_chunk;
      bit                           talking;
      bit                           gap_pending;
      bit                           held_valid;
      logic [sst_pkg::TIME_W-1:0]   open_start;
      logic [sst_pkg::TIME_W-1:0]   gap_start;
      logic [sst_pkg::TIME_W-1:0]   position;
      logic [sst_pkg::TIME_W-1:0]   total;
      logic [sst_pkg::TIME_W-1:0]   held_start;
      logic [sst_pkg::TIME_W-1:0]   held_end;
      sst_pkg::rsp_item_type        due_segments[$];
      int unsigned                  mismatches;

      function new();
         thr = 17'd32768;
         min_gap = 20'd4800;
         grace = 20'd800;
         min_chunk = 20'd3200;
         mismatches = 0;
         clear_stream();
      endfunction

      function void clear_stream();
         talking = 1'b0;
         gap_pending = 1'b0;
         held_valid = 1'b0;
         open_start = '0;
         gap_start = '0;
         position = '0;
         total = '0;
         held_start = '0;
         held_end = '0;
      endfunction

      function int unsigned pending();
         return due_segments.size();
      endfunction

      function void write_field(logic [sst_pkg::INDEX_W-1:0] idx,
                                logic [sst_pkg::CFG_W-1:0] data);
         case (idx)
            sst_pkg::REG_SPEECH_THRESHOLD:  thr = data[sst_pkg::THRESH_W-1:0];
            sst_pkg::REG_MIN_GAP_SAMPLES:   min_gap = data;
            sst_pkg::REG_GRACE_SAMPLES:     grace = data;
            sst_pkg::REG_MIN_CHUNK_SAMPLES: min_chunk = data;
            default: ;
         endcase
      endfunction

      function void emit(logic [sst_pkg::TIME_W-1:0] s, logic [sst_pkg::TIME_W-1:0] e,
                         logic has);
         sst_pkg::rsp_item_type r;
         r.seg_start = s;
         r.seg_end = e;
         r.has_segment = has;
         r.stream_done = 1'b0;
         due_segments.insert(due_segments.size(), r);
      endfunction

      // The held segment goes out clamped to the samples seen, if long enough.
      function void flush_held();
         logic [sst_pkg::TIME_W-1:0] ce;
         if (held_valid) begin
            ce = (held_end < total) ? held_end : total;
            if (ce >= held_start && ce - held_start >= min_chunk)
               emit(held_start, ce, 1'b1);
            held_valid = 1'b0;
         end
      endfunction

      // Pad a closed segment, drop it if empty, else merge it or hold it.
      function void close_segment(logic [sst_pkg::TIME_W-1:0] s0,
                                  logic [sst_pkg::TIME_W-1:0] e0);
         logic [sst_pkg::TIME_W-1:0] s;
         logic [sst_pkg::TIME_W-1:0] e;
         logic [sst_pkg::TIME_W-1:0] ce;
         logic [sst_pkg::TIME_W:0]   wide;
         s = (s0 >= grace) ? s0 - grace : '0;
         wide = {1'b0, e0} + grace;
         e = wide[sst_pkg::TIME_W] ? '1 : wide[sst_pkg::TIME_W-1:0];
         ce = (e < total) ? e : total;
         if (ce <= s)
            return;
         if (held_valid && s <= held_end) begin
            if (e > held_end)
               held_end = e;
            return;
         end
         flush_held();
         held_valid = 1'b1;
         held_start = s;
         held_end = e;
      endfunction

      // Work out the segment items that one accepted input item causes.
      function void take_item(logic kind, logic [sst_pkg::PROB_W-1:0] prob,
                              logic [sst_pkg::VALID_W-1:0] count);
         int unsigned                 queued;
         logic [sst_pkg::VALID_W-1:0] used;
         logic [sst_pkg::TIME_W-1:0]  fstart;
         logic [sst_pkg::TIME_W-1:0]  fend;
         bit                          loud;
         if (kind == sst_pkg::MODE_END) begin
            queued = due_segments.size();
            if (talking)
               close_segment(open_start, gap_pending ? gap_start : total);
            flush_held();
            // An end with nothing to emit still gives a bare end marker.
            if (due_segments.size() == queued)
               emit('0, '0, 1'b0);
            due_segments[due_segments.size() - 1].stream_done = 1'b1;
            clear_stream();
            return;
         end
         used = (count > sst_pkg::VALID_W'(sst_pkg::FRAME_LEN)) ?
                sst_pkg::VALID_W'(sst_pkg::FRAME_LEN) : count;
         total = total + used;
         loud = {1'b0, prob} >= thr;
         fstart = position;
         fend = fstart + sst_pkg::TIME_W'(sst_pkg::FRAME_LEN);
         if (!talking) begin
            if (loud) begin
               talking = 1'b1;
               open_start = fstart;
               gap_pending = 1'b0;
            end
         end else if (loud) begin
            gap_pending = 1'b0;
         end else if (!gap_pending) begin
            gap_pending = 1'b1;
            gap_start = fstart;
         end else if (fend - gap_start >= min_gap) begin
            close_segment(open_start, gap_start);
            talking = 1'b0;
            gap_pending = 1'b0;
         end
         position = fend;
      endfunction

      task report_mismatch(string what, logic [sst_pkg::TIME_W-1:0] got,
                           logic [sst_pkg::TIME_W-1:0] want);
         $display("mismatch in %s: got %0d, expected %0d", what, got, want);
         mismatches++;
      endtask

      task match_result(sst_pkg::rsp_item_type got);
         sst_pkg::rsp_item_type want;
         if (due_segments.size() == 0) begin
            report_mismatch("unexpected result seg_start", got.seg_start, '0);
            return;
         end
         want = due_segments[0];
         due_segments.delete(0);
         if (got.seg_start !== want.seg_start)
            report_mismatch("seg_start", got.seg_start, want.seg_start);
         if (got.seg_end !== want.seg_end)
            report_mismatch("seg_end", got.seg_end, want.seg_end);
         if (got.has_segment !== want.has_segment)
            report_mismatch("has_segment", sst_pkg::TIME_W'(got.has_segment),
                            sst_pkg::TIME_W'(want.has_segment));
         if (got.stream_done !== want.stream_done)
            report_mismatch("stream_done", sst_pkg::TIME_W'(got.stream_done),
                            sst_pkg::TIME_W'(want.stream_done));
      endtask
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [31:0]                  req_tdata = '0;   // speech_prob[15:0], valid_samples[25:16]
   logic                         req_tuser = 1'b0; // mode
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [63:0]                  rsp_tdata;        // seg_start[31:0], seg_end[63:32]
   logic                         rsp_tuser;        // has_segment
   logic                         rsp_tlast;        // stream_done
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [sst_pkg::INDEX_W-1:0]  csr_index = '0;
   logic [sst_pkg::CFG_W-1:0]    csr_data = '0;

   segment_ledger     ledger;
   bit                quiet = 1'b0;
   int unsigned       sent = 0;
   int unsigned       cycles = 0;
   sst_pkg::cfg_type  plan [6];

   speech_segment_tracker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Result side: check each accepted item and stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
         ledger.match_result({rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser, rsp_tlast});
      rsp_tready <= quiet || ($urandom_range(99) >= 37);
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("speech_segment_tracker_test: FAIL");
         $finish;
      end
   end

   // Offer one item, idling at random first, and note it once it is taken.
   task automatic send_item(input logic kind, input logic [sst_pkg::PROB_W-1:0] prob,
                            input logic [sst_pkg::VALID_W-1:0] count);
      while (!quiet && $urandom_range(99) < 37) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {6'd0, count, prob};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      ledger.take_item(kind, prob, count);
      sent++;
   endtask

   // Stop sending and wait until every owed segment has come out.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (ledger.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [sst_pkg::INDEX_W-1:0] idx,
                            input logic [sst_pkg::CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      ledger.write_field(idx, data);
   endtask

   // Write all four registers; the threshold gets junk in its unused upper bits.
   task automatic write_config(input sst_pkg::cfg_type c);
      write_reg(sst_pkg::REG_SPEECH_THRESHOLD, {3'($urandom), c.speech_threshold});
      write_reg(sst_pkg::REG_MIN_GAP_SAMPLES, c.min_gap_samples);
      write_reg(sst_pkg::REG_GRACE_SAMPLES, c.grace_samples);
      write_reg(sst_pkg::REG_MIN_CHUNK_SAMPLES, c.min_chunk_samples);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Probability on the chosen side of the threshold, with some pure noise.
   function automatic logic [sst_pkg::PROB_W-1:0] pick_prob(input bit loud);
      logic [sst_pkg::THRESH_W-1:0] t;
      t = ledger.thr;
      if ($urandom_range(99) < 10)
         return sst_pkg::PROB_W'($urandom);
      if (loud)
         return (t > 17'd65535) ? sst_pkg::PROB_W'($urandom) :
                                  sst_pkg::PROB_W'($urandom_range(65535, t));
      return (t == 0) ? sst_pkg::PROB_W'($urandom) : sst_pkg::PROB_W'($urandom_range(t - 1, 0));
   endfunction

   // Mostly full frames, some partial, empty or oversized ones.
   function automatic logic [sst_pkg::VALID_W-1:0] pick_count();
      if ($urandom_range(99) < 15)
         return sst_pkg::VALID_W'($urandom_range(1023, 0));
      return sst_pkg::VALID_W'(sst_pkg::FRAME_LEN);
   endfunction

   // Streams of speech bursts and silences, most of them closed by an end item.
   task automatic random_phase(input int unsigned quota, input bit hold_midway);
      int unsigned first;
      int unsigned bursts;
      int unsigned hush;
      int unsigned b;
      first = sent;
      hush = ledger.min_gap / sst_pkg::FRAME_LEN + 3;
      if (hush > 14)
         hush = 14;
      while (sent - first < quota) begin
         bursts = $urandom_range(4, 1);
         for (b = 0; b < bursts; b++) begin
            repeat ($urandom_range(6, 1))
               send_item(sst_pkg::MODE_FRAME, pick_prob(1'b1), pick_count());
            repeat ($urandom_range(hush, 0))
               send_item(sst_pkg::MODE_FRAME, pick_prob(1'b0), pick_count());
         end
         if ($urandom_range(99) < 85)
            send_item(sst_pkg::MODE_END, sst_pkg::PROB_W'($urandom),
                      sst_pkg::VALID_W'($urandom));
         // Let the block run dry once in the middle of a phase.
         if (hold_midway && sent - first >= quota / 2) begin
            hold_midway = 1'b0;
            drain();
         end
      end
   endtask

   initial begin
      ledger = new();
      plan[0] = '{17'd32768, 20'd4800, 20'd800, 20'd3200};
      plan[1] = '{17'd0, 20'd0, 20'd0, 20'd0};
      plan[2] = '{17'd65536, 20'd1024, 20'd800, 20'd1000};
      plan[3] = '{17'd20000, 20'd1536, 20'hFFFFF, 20'hFFFFF};
      plan[4] = '{17'd45000, 20'd2048, 20'd300, 20'd1500};
      plan[5] = '{17'($urandom_range(70000, 0)), 20'($urandom_range(5000, 0)),
                  20'($urandom_range(2000, 0)), 20'($urandom_range(4000, 0))};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: a short gap so that segments close after two silent frames.
      write_config('{17'd32768, 20'd1024, 20'd800, 20'd3200});
      send_item(sst_pkg::MODE_END, 16'd0, 10'd0);        // bare end marker
      send_item(sst_pkg::MODE_FRAME, 16'd0, 10'd512);    // silence before any speech
      send_item(sst_pkg::MODE_FRAME, 16'd32768, 10'd512); // exactly at the threshold
      send_item(sst_pkg::MODE_FRAME, 16'hFFFF, 10'd512);
      send_item(sst_pkg::MODE_FRAME, 16'd32767, 10'd512); // just below: gap starts
      send_item(sst_pkg::MODE_FRAME, 16'hFFFF, 10'd512); // speech cancels the gap
      send_item(sst_pkg::MODE_FRAME, 16'd0, 10'd512);
      send_item(sst_pkg::MODE_FRAME, 16'd0, 10'd512);    // segment closes and is held
      send_item(sst_pkg::MODE_FRAME, 16'd40000, 10'h3FF); // oversized count saturates
      send_item(sst_pkg::MODE_FRAME, 16'd0, 10'd512);
      send_item(sst_pkg::MODE_FRAME, 16'd0, 10'd512);    // overlaps the held one: merged
      send_item(sst_pkg::MODE_FRAME, 16'd0, 10'd512);
      send_item(sst_pkg::MODE_FRAME, 16'd0, 10'd512);
      send_item(sst_pkg::MODE_FRAME, 16'd0, 10'd512);
      send_item(sst_pkg::MODE_FRAME, 16'd50000, 10'd512);
      send_item(sst_pkg::MODE_FRAME, 16'd1, 10'd512);
      send_item(sst_pkg::MODE_FRAME, 16'd1, 10'd512);    // held one goes out, new one held
      send_item(sst_pkg::MODE_FRAME, 16'd60000, 10'd0);  // speech with no samples
      send_item(sst_pkg::MODE_END, 16'hFFFF, 10'h3FF);   // open merged into held, one flushed
      send_item(sst_pkg::MODE_FRAME, 16'hFFFF, 10'd0);
      send_item(sst_pkg::MODE_FRAME, 16'd0, 10'd0);
      send_item(sst_pkg::MODE_FRAME, 16'd0, 10'd0);      // nothing seen: empty, dropped
      send_item(sst_pkg::MODE_END, 16'h5555, 10'h2AA);
      drain();

      // Random part under several settings, one of them without any idling.
      for (int ph = 0; ph < 6; ph++) begin
         write_config(plan[ph]);
         quiet = (ph == 4);
         random_phase(55, ph == 2);
         drain();
      end
      quiet = 1'b0;

      if (ledger.mismatches == 0 && ledger.pending() == 0)
         $display("speech_segment_tracker_test: PASS");
      else
         $display("speech_segment_tracker_test: FAIL");
      $finish;
   end

endmodule

/* files.f */
rtl/sst_pkg.sv
rtl/sst_seg_logic.sv
rtl/sst_rsp_fifo.sv
rtl/speech_segment_tracker.sv
verif/speech_segment_tracker_test.sv
